[hdl/limited_linear_upwind_face_correction_defines.svh]
// Assertion macros for the limited linear-upwind face correction block.
`ifndef LIMITED_LINEAR_UPWIND_FACE_CORRECTION_DEFINES_SVH
`define LIMITED_LINEAR_UPWIND_FACE_CORRECTION_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define LLU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define LLU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hdl/lluf_pkg.sv]
// Package with types and constants of the limited linear-upwind face correction block.
package lluf_pkg;
    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int SAT_BITS = (WORD_BITS > 32) ? 32 : WORD_BITS;

    typedef struct packed {
        logic [4:0]         slot;
        logic signed [31:0] operand;
        logic               compute_now;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         component;
        logic signed [31:0] corrected;
        logic               final_component;
    } out_item_t;

    localparam logic [4:0] SLOT_FLUX   = 5'd0;
    localparam logic [4:0] SLOT_WEIGHT = 5'd1;
    localparam logic [4:0] SLOT_VO     = 5'd2;
    localparam logic [4:0] SLOT_VN     = 5'd5;
    localparam logic [4:0] SLOT_DO     = 5'd8;
    localparam logic [4:0] SLOT_DN     = 5'd11;
    localparam logic [4:0] SLOT_GO     = 5'd14;
    localparam logic [4:0] SLOT_GN     = 5'd23;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD,
        ST_BOUND,
        ST_CORR,
        ST_NORM,
        ST_DECIDE,
        ST_DIVIDE,
        ST_SCALE,
        ST_EMIT
    } state_t;

    // Saturate a wide signed value to SAT_BITS, returned in 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [79:0] x);
        logic signed [79:0] lim;
        lim = (80'sd1 <<< (SAT_BITS - 1)) - 80'sd1;
        if (x > lim)
            sat32 = 32'(lim);
        else if (x < -lim - 80'sd1)
            sat32 = 32'(-lim - 80'sd1);
        else
            sat32 = 32'(x);
    endfunction
endpackage

[hdl/limited_linear_upwind_face_correction.sv]
// Top level of the limited linear-upwind face correction block.
//
//  channel   direction  handshake              payload
//  in_item   input      start high, busy low   slot, operand, compute_now
//  out_item  output     valid per result       component, corrected, final_component
//
// A load item leaves busy low, and the next item may follow at once.
// A compute item holds busy high until its last result, longer when the correction is scaled:
// the store has one read port, so operands are fetched one a cycle into one shared
// 32x32 multiplier, and the scale ratio comes from a restoring divider, one bit a cycle.
// The three results leave on consecutive cycles, z marked last; busy drops with z.
// Reset clears the control state only; the store holds undefined words until written.
module limited_linear_upwind_face_correction (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  lluf_pkg::in_item_t   in_item,
    output logic                 valid,
    output lluf_pkg::out_item_t  out_item
);
    import lluf_pkg::*;

    // Operand store: one write port, one registered read port.
    logic [31:0] store_mem [32];
    logic [4:0]  rd_addr;
    logic signed [31:0] rd_data_reg;

    state_t state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic ownside_reg, ownside_next;
    logic signed [31:0] fac_reg, fac_next;
    logic signed [31:0] vo_reg, vo_next;
    logic signed [31:0] bound_reg [3];
    logic signed [31:0] corr_reg [3];
    logic signed [31:0] disp_reg [3];
    logic signed [79:0] acc_reg, acc_next;
    logic signed [79:0] hs_reg, hs_next;
    logic signed [79:0] ls_reg, ls_next;
    logic signed [79:0] m_reg, m_next;
    logic signed [79:0] rem_reg, rem_next;
    logic [FRAC_BITS-1:0] ratio_reg, ratio_next;
    logic signed [63:0] prod_reg;
    logic signed [31:0] mul_a, mul_b;
    logic busy_reg, busy_next;
    logic valid_reg, valid_next;
    out_item_t out_reg, out_next;

    // Write-enables into small register arrays.
    logic       bound_we, corr_we, disp_we, corr_zero;
    logic [1:0] sel_idx;
    logic signed [31:0] wr_val;

    logic accept;
    assign accept = start && !busy_reg;
    assign busy = busy_reg;
    assign valid = valid_reg;
    assign out_item = out_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
            store_mem[in_item.slot] <= in_item.operand;
        rd_data_reg <= store_mem[rd_addr];
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk)
    begin
        if (bound_we)
            bound_reg[sel_idx] <= wr_val;
        if (disp_we)
            disp_reg[sel_idx] <= rd_data_reg;
        if (corr_we)
            corr_reg[sel_idx] <= wr_val;
        if (corr_zero)
        begin
            corr_reg[0] <= '0;
            corr_reg[1] <= '0;
            corr_reg[2] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg    <= step_next;
        ownside_reg <= ownside_next;
        fac_reg     <= fac_next;
        vo_reg      <= vo_next;
        acc_reg     <= acc_next;
        hs_reg      <= hs_next;
        ls_reg      <= ls_next;
        m_reg       <= m_next;
        rem_reg     <= rem_next;
        ratio_reg   <= ratio_next;
        out_reg     <= out_next;
    end

    // Round a single product to nearest, ties up.
    function automatic logic signed [79:0] round_prod(input logic signed [63:0] p);
        logic signed [79:0] t;
        t = 80'(p) + (80'sd1 <<< (FRAC_BITS - 1));
        round_prod = t >>> FRAC_BITS;
    endfunction

    logic signed [79:0] p_wide, p_hi, ls_sum, dot_res;
    logic signed [79:0] rem2;
    always_comb
    begin
        p_wide = 80'(prod_reg);
        p_hi   = p_wide >>> FRAC_BITS;
        // Dot-product finish: hs plus rounded remainder sum, using current product.
        ls_sum = ls_reg + (p_wide - (p_hi <<< FRAC_BITS)) + (80'sd1 <<< (FRAC_BITS - 1));
        dot_res = hs_reg + p_hi + (ls_sum >>> FRAC_BITS);
        rem2 = rem_reg <<< 1;
    end

    // Sequencer. Multiplier operands are chosen per step; the product is
    // registered and consumed in the next cycle.
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        ownside_next = ownside_reg;
        fac_next     = fac_reg;
        vo_next      = vo_reg;
        acc_next     = acc_reg;
        hs_next      = hs_reg;
        ls_next      = ls_reg;
        m_next       = m_reg;
        rem_next     = rem_reg;
        ratio_next   = ratio_reg;
        busy_next    = busy_reg;
        valid_next   = 1'b0;
        out_next     = out_reg;
        rd_addr      = SLOT_FLUX;
        mul_a        = '0;
        mul_b        = '0;
        bound_we     = 1'b0;
        corr_we      = 1'b0;
        disp_we      = 1'b0;
        corr_zero    = 1'b0;
        sel_idx      = 2'd0;
        wr_val       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_item.compute_now)
                begin
                    busy_next  = 1'b1;
                    step_next  = '0;
                    state_next = ST_HEAD;
                end
            end

            // step 0: read flux; 1: flux arrives, read weight; 2: weight arrives.
            ST_HEAD:
            begin
                step_next = step_reg + 5'd1;
                case (step_reg)
                    5'd0: rd_addr = SLOT_FLUX;
                    5'd1:
                    begin
                        ownside_next = (rd_data_reg > 0);
                        rd_addr = SLOT_WEIGHT;
                    end
                    default:
                    begin
                        fac_next = ownside_reg
                            ? sat32((80'sd1 <<< FRAC_BITS) - 80'(rd_data_reg))
                            : rd_data_reg;
                        rd_addr = SLOT_VO;
                        step_next = '0;
                        state_next = ST_BOUND;
                    end
                endcase
            end

            // Per component i (4 steps): vo arrives, read vn; vn arrives, multiply;
            // product ready, write bound; read the next operand.
            ST_BOUND:
            begin
                step_next = step_reg + 5'd1;
                sel_idx = 2'(step_reg >> 2);
                case (step_reg[1:0])
                    2'd0:
                    begin
                        vo_next = rd_data_reg;
                        rd_addr = SLOT_VN + 5'(step_reg >> 2);
                    end
                    2'd1:
                    begin
                        mul_a = fac_reg;
                        mul_b = ownside_reg
                            ? sat32(80'(rd_data_reg) - 80'(vo_reg))
                            : sat32(80'(vo_reg) - 80'(rd_data_reg));
                    end
                    2'd2:
                    begin
                        bound_we = 1'b1;
                        wr_val = sat32(round_prod(prod_reg));
                    end
                    default:
                    begin
                        if (step_reg[3:2] == 2'd2)
                        begin
                            step_next = '0;
                            rd_addr = ownside_reg ? SLOT_DO : SLOT_DN;
                            state_next = ST_CORR;
                        end
                        else
                            rd_addr = SLOT_VO + 5'(step_reg >> 2) + 5'd1;
                    end
                endcase
            end

            // Steps 0-2: displacements arrive. Then for row i, column j: issue read
            // of G[j][i] (stride 3 over rows), multiply on arrival, accumulate.
            ST_CORR:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg < 5'd3)
                begin
                    disp_we = 1'b1;
                    sel_idx = 2'(step_reg);
                    if (step_reg < 5'd2)
                        rd_addr = (ownside_reg ? SLOT_DO : SLOT_DN) + step_reg + 5'd1;
                    else
                        rd_addr = ownside_reg ? SLOT_GO : SLOT_GN;
                    hs_next = '0;
                    ls_next = '0;
                end
                else
                begin
                    // k = step-3 in 0..11: component i = k/4, phase k%4.
                    // phase 0..2: data for j=phase arrives (read issued previously).
                    // Product j lands in the next phase; phase 3 closes the component
                    // and reads the first gradient of the next one.
                    logic [4:0] k;
                    logic [1:0] ci, ph;
                    k  = step_reg - 5'd3;
                    ci = 2'(k >> 2);
                    ph = k[1:0];
                    if (ph != 2'd3)
                    begin
                        mul_a = disp_reg[ph];
                        mul_b = rd_data_reg;
                    end
                    if (ph != 2'd0)
                    begin
                        hs_next = hs_reg + p_hi;
                        ls_next = ls_reg + (p_wide - (p_hi <<< FRAC_BITS));
                    end
                    if (ph < 2'd2)
                        rd_addr = (ownside_reg ? SLOT_GO : SLOT_GN)
                                  + 5'(3 * (ph + 2'd1)) + 5'(ci);
                    else if (ph == 2'd3 && ci != 2'd2)
                        rd_addr = (ownside_reg ? SLOT_GO : SLOT_GN) + 5'(ci) + 5'd1;
                    if (ph == 2'd3)
                    begin
                        corr_we = 1'b1;
                        sel_idx = ci;
                        wr_val = sat32(dot_res);
                        hs_next = '0;
                        ls_next = '0;
                        if (ci == 2'd2)
                        begin
                            step_next = '0;
                            state_next = ST_NORM;
                        end
                    end
                end
            end

            // Steps 0-2 magnitude products, 3-5 dot products, 6 finish.
            ST_NORM:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg < 5'd3)
                begin
                    mul_a = corr_reg[step_reg[1:0]];
                    mul_b = corr_reg[step_reg[1:0]];
                end
                else if (step_reg < 5'd6)
                begin
                    mul_a = corr_reg[2'(step_reg - 5'd3)];
                    mul_b = bound_reg[2'(step_reg - 5'd3)];
                end
                if (step_reg >= 5'd1 && step_reg != 5'd3)
                begin
                    hs_next = hs_reg + p_hi;
                    ls_next = ls_reg + (p_wide - (p_hi <<< FRAC_BITS));
                end
                if (step_reg == 5'd3)
                begin
                    m_next = dot_res;
                    hs_next = '0;
                    ls_next = '0;
                end
                if (step_reg == 5'd6)
                begin
                    acc_next = dot_res;
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                step_next = '0;
                rem_next = acc_reg;
                ratio_next = '0;
                if (m_reg > 0 && acc_reg < 0)
                begin
                    corr_zero = 1'b1;
                    state_next = ST_EMIT;
                end
                else if (m_reg > 0 && m_reg > acc_reg)
                    state_next = ST_DIVIDE;
                else
                    state_next = ST_EMIT;
            end

            ST_DIVIDE:
            begin
                step_next = step_reg + 5'd1;
                if (rem2 >= m_reg)
                begin
                    rem_next = rem2 - m_reg;
                    ratio_next = {ratio_reg[FRAC_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2;
                    ratio_next = {ratio_reg[FRAC_BITS-2:0], 1'b0};
                end
                if (step_reg == 5'(FRAC_BITS - 1))
                begin
                    step_next = '0;
                    state_next = ST_SCALE;
                end
            end

            // Steps 0-2 multiply, 1-3 write back.
            ST_SCALE:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg < 5'd3)
                begin
                    mul_a = corr_reg[step_reg[1:0]];
                    mul_b = 32'(ratio_reg);
                end
                if (step_reg != 5'd0)
                begin
                    corr_we = 1'b1;
                    sel_idx = 2'(step_reg - 5'd1);
                    wr_val = sat32(round_prod(prod_reg));
                end
                if (step_reg == 5'd3)
                begin
                    step_next = '0;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                step_next = step_reg + 5'd1;
                valid_next = 1'b1;
                out_next.component = step_reg[1:0];
                out_next.corrected = corr_reg[step_reg[1:0]];
                out_next.final_component = (step_reg == 5'd2);
                if (step_reg == 5'd2)
                begin
                    busy_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end
endmodule

[hdl/lluf_checker.sv]
// Port checker for the limited linear-upwind face correction block.
`include "limited_linear_upwind_face_correction_defines.svh"
module lluf_port_assertions (
    input logic                clk,
    input logic                rst_n,
    input logic                busy,
    input logic                valid,
    input lluf_pkg::out_item_t out_item
);
    logic last_flag;
    logic x_shown;
    logic y_shown;
    logic z_shown;

    assign last_flag = out_item.final_component;
    assign x_shown = (out_item.component == 2'd0);
    assign y_shown = (out_item.component == 2'd1);
    assign z_shown = (out_item.component == 2'd2);

    `LLU_ASSERT_IMPL(a_valid_busy, clk, rst_n, valid, busy || last_flag, "result while idle")
    `LLU_ASSERT_IMPL(a_comp_range, clk, rst_n, valid, out_item.component != 2'd3, "bad component")
    `LLU_ASSERT_IMPL(a_final_z, clk, rst_n, valid, last_flag == z_shown, "final flag mismatch")
    `LLU_ASSERT_NEXT(a_x_then_y, clk, rst_n, valid && x_shown, valid && y_shown, "y does not follow x")
endmodule

bind limited_linear_upwind_face_correction lluf_port_assertions u_lluf_port_assertions (
    .clk(clk), .rst_n(rst_n), .busy(busy),
    .valid(valid), .out_item(out_item)
);

[tb/sv/lluf_checker.sv]
// Checker that predicts and compares the face correction results of the block.
module lluf_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  lluf_pkg::in_item_t  in_item,
    input  logic                valid,
    input  lluf_pkg::out_item_t out_item,
    output int                  fail_count,
    output int                  pending
);
    import lluf_pkg::*;

    localparam longint ONE = 64'sd1 <<< FRAC_BITS;

    logic [31:0] face_words [32];
    out_item_t   awaited_results [$];

    function automatic longint word_at(int idx);
        return longint'($signed(face_words[idx]));
    endfunction

    function automatic longint clamp_sat(longint x);
        longint lim;
        lim = (64'sd1 <<< (SAT_BITS - 1)) - 1;
        if (x > lim)
            return lim;
        if (x < -lim - 1)
            return -lim - 1;
        return x;
    endfunction

    function automatic longint round_prod(longint a, longint b);
        return (a * b + (ONE >>> 1)) >>> FRAC_BITS;
    endfunction

    // Three products summed exactly and rounded once; the integer and
    // fraction parts are kept apart so that the sum cannot overflow.
    function automatic longint sum3_round(longint a0, longint a1, longint a2,
                                          longint b0, longint b1, longint b2);
        longint p [3];
        longint hs, ls, h;
        p[0] = a0 * b0;
        p[1] = a1 * b1;
        p[2] = a2 * b2;
        hs = 0;
        ls = 0;
        for (int i = 0; i < 3; i++)
        begin
            h = p[i] >>> FRAC_BITS;
            hs += h;
            ls += p[i] - (h <<< FRAC_BITS);
        end
        return hs + ((ls + (ONE >>> 1)) >>> FRAC_BITS);
    endfunction

    task automatic predict_face();
        longint fac, diff, m, d, rem, ratio;
        longint bnd [3];
        longint cor [3];
        longint dsp [3];
        longint g [9];
        bit     own;
        int     db, gb;
        out_item_t r;
        own = word_at(SLOT_FLUX) > 0;
        fac = own ? clamp_sat(ONE - word_at(SLOT_WEIGHT)) : word_at(SLOT_WEIGHT);
        for (int i = 0; i < 3; i++)
        begin
            diff = own ? clamp_sat(word_at(SLOT_VN + i) - word_at(SLOT_VO + i))
                       : clamp_sat(word_at(SLOT_VO + i) - word_at(SLOT_VN + i));
            bnd[i] = clamp_sat(round_prod(fac, diff));
        end
        db = own ? SLOT_DO : SLOT_DN;
        gb = own ? SLOT_GO : SLOT_GN;
        for (int i = 0; i < 3; i++)
            dsp[i] = word_at(db + i);
        for (int i = 0; i < 9; i++)
            g[i] = word_at(gb + i);
        for (int i = 0; i < 3; i++)
            cor[i] = clamp_sat(sum3_round(dsp[0], dsp[1], dsp[2], g[i], g[i + 3], g[i + 6]));
        m = sum3_round(cor[0], cor[1], cor[2], cor[0], cor[1], cor[2]);
        d = sum3_round(cor[0], cor[1], cor[2], bnd[0], bnd[1], bnd[2]);
        if (m > 0)
        begin
            if (d < 0)
            begin
                for (int i = 0; i < 3; i++)
                    cor[i] = 0;
            end
            else if (m > d)
            begin
                rem = d;
                ratio = 0;
                for (int i = 0; i < FRAC_BITS; i++)
                begin
                    rem = rem * 2;
                    ratio = ratio * 2;
                    if (rem >= m)
                    begin
                        rem -= m;
                        ratio |= 1;
                    end
                end
                for (int i = 0; i < 3; i++)
                    cor[i] = clamp_sat(round_prod(cor[i], ratio));
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            r.component = 2'(i);
            r.corrected = 32'(cor[i]);
            r.final_component = (i == 2);
            awaited_results.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (valid)
            begin
                if (awaited_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("Unexpected result: component %0d value %0d",
                                 out_item.component, out_item.corrected);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = awaited_results.pop_front();
                    if (e !== out_item)
                    begin
                        if (fail_count < 10)
                            $display("Mismatch: expected c%0d %0d f%0d, got c%0d %0d f%0d",
                                     e.component, e.corrected, e.final_component,
                                     out_item.component, out_item.corrected,
                                     out_item.final_component);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
            begin
                face_words[in_item.slot] = in_item.operand;
                if (in_item.compute_now)
                    predict_face();
            end
            pending <= awaited_results.size();
        end
    end
endmodule

[tb/sv/tb.sv]
// Testbench top: stimulus and verdict for the face correction block.
module tb;
    import lluf_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    in_item_t  in_item = '0;
    logic      valid;
    out_item_t out_item;
    int        fail_count;
    int        pending;
    int        cycle_count = 0;
    int        idle_pct = 27;

    always #5 clk = ~clk;

    limited_linear_upwind_face_correction dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .in_item(in_item), .valid(valid), .out_item(out_item)
    );

    lluf_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
        .valid(valid), .out_item(out_item), .fail_count(fail_count), .pending(pending)
    );

    // Watchdog: even with the slowest compute items, the loads and the idle gaps,
    // this limit is many times what a correct run needs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Sends one item, holding start until the block takes it. Random idle
    // cycles are inserted before the item at the current rate. Start is left
    // high afterwards; the next item or a pause takes it down.
    task automatic send_item(logic [4:0] s, logic [31:0] v, logic go);
        while ($urandom_range(99, 0) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        in_item <= '{slot: s, operand: v, compute_now: go};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Stops sending and waits until every awaited result has arrived.
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Produces an operand of a random kind: full range, small, or an extreme.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(5, 0))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return 32'($signed($urandom_range(8 << 16, 0)) - (4 << 16));
            default: return 32'($signed($urandom_range(2 << 16, 0)) - (1 << 16));
        endcase
    endfunction

    // Loads every slot of a face in random order, the last one carrying the
    // compute request. The flux and weight are steered to hit each side.
    task automatic send_face(int kind);
        int order [32];
        int j, t;
        logic [31:0] v;
        for (int i = 0; i < 32; i++)
            order[i] = i;
        for (int i = 31; i > 0; i--)
        begin
            j = $urandom_range(i, 0);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < 32; i++)
        begin
            v = pick_value();
            if (order[i] == SLOT_FLUX)
            begin
                case (kind)
                    0: v = 32'd0;
                    1: v = 32'h0001_0000;
                    2: v = 32'hFFFF_0000;
                    default: v = $urandom();
                endcase
            end
            else if (order[i] == SLOT_WEIGHT && kind != 3)
                v = $urandom_range(1 << 16, 0);
            else if (kind == 4 && order[i] >= SLOT_DO)
                v = 32'd0;
            send_item(5'(order[i]), v, i == 31);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero flux, positive and negative flux, wild values, and
        // a zero correction (rounded magnitude zero passes unchanged).
        idle_pct = 0;
        for (int k = 0; k < 5; k++)
            send_face(k);
        // Extra computes on a full store, each also overwriting the flux or the weight.
        send_item(SLOT_FLUX, 32'h8000_0000, 1'b1);
        send_item(SLOT_WEIGHT, 32'h7FFF_FFFF, 1'b1);

        // Random single words with random compute requests on the full store.
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 27 : (phase == 1) ? 79 : 0;
            for (int n = 0; n < 16; n++)
                send_item(5'($urandom_range(31, 0)), pick_value(), $urandom_range(1, 0));
            if (phase == 0)
            begin
                // Hold off until every awaited result has arrived.
                wait_for_results();
            end
        end

        idle_pct = 0;
        wait_for_results();
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
